FILE: rtl/core/sett_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and lane command type for the sensor edge timestamp tracker.
package sett_pkg;

  localparam int DEF_NUM_SENSORS = 80;
  localparam int DEF_TIME_BITS   = 32;

  localparam int LANES     = 8;
  localparam int LANE_W    = 3;
  localparam int ROW_IDX_W = 4;
  localparam int ID_W      = 7;
  localparam int STAMP_W   = 32;

  localparam logic [1:0] CMD_BATCH  = 2'd0;
  localparam logic [1:0] CMD_SINGLE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] KIND_TRIGGER = 2'd0;
  localparam logic [1:0] KIND_STATUS  = 2'd1;
  localparam logic [1:0] KIND_INVALID = 2'd2;

  typedef struct packed {
    logic                 batch;
    logic                 single;
    logic                 query;
    logic                 sel;
    logic                 din;
    logic [ROW_IDX_W-1:0] row;
  } lane_cmd_t;

endpackage

FILE: rtl/core/sensor_edge_timestamp_tracker.sv
`timescale 1ns / 1ps
// Top level of the sensor edge timestamp tracker: command decode, eight lanes and merge stage.
// Tracks a held flag and a rising-edge timestamp per contact sensor. Eight lanes each own every
// eighth sensor, so a whole batch byte is checked and its held flags and stamps updated in the
// cycle it is accepted; the merge stage then sends out one beat per cycle while the output is not
// stalled. A batch byte yields one beat per new edge (up to eight), a single-sensor command at most
// one and a status query exactly one; an item that yields no result does not occupy the merge stage.
// A new item is taken in the cycle its predecessor's final beat moves to the output register. Status
// replies read the stamp memory through a registered port. Reset clears held flags and stamp valid
// bits at once; no clearing pass is needed.
module sensor_edge_timestamp_tracker #(
  parameter int NUM_SENSORS = sett_pkg::DEF_NUM_SENSORS,
  parameter int TIME_BITS   = sett_pkg::DEF_TIME_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     command,
  input  logic [sett_pkg::ROW_IDX_W-1:0] byte_index,
  input  logic [7:0]                     byte_value,
  input  logic [sett_pkg::ID_W-1:0]      sensor_number,
  input  logic [31:0]                    now_time,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     kind,
  output logic [sett_pkg::ID_W-1:0]      sensor_id,
  output logic                           held,
  output logic [sett_pkg::STAMP_W-1:0]   stamp,
  output logic                           last
);
  import sett_pkg::*;

  logic                 accept;
  logic                 busy;
  logic                 sensor_ok;
  logic [ID_W-1:0]      sensor_idx;
  logic                 do_batch;
  logic                 do_single;
  logic                 do_query;
  logic [ROW_IDX_W-1:0] row;
  logic [TIME_BITS-1:0] now_t;

  lane_cmd_t                         lane_cmd [LANES];
  logic [LANES-1:0]                  trig;
  logic [LANES-1:0]                  rd_held;
  logic [LANES-1:0][TIME_BITS-1:0]   rd_stamp;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  assign sensor_ok  = (sensor_number != '0) && ({1'b0, sensor_number} <= 8'(NUM_SENSORS));
  assign sensor_idx = sensor_number - ID_W'(1);
  assign do_batch   = accept && (command == CMD_BATCH);
  assign do_single  = accept && (command == CMD_SINGLE) && sensor_ok;
  assign do_query   = accept && (command == CMD_QUERY);
  assign row        = do_batch ? byte_index : sensor_idx[ID_W-1:LANE_W];
  assign now_t      = TIME_BITS'(now_time);

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    always_comb begin
      lane_cmd[k].batch  = do_batch;
      lane_cmd[k].single = do_single;
      lane_cmd[k].query  = do_query && sensor_ok;
      lane_cmd[k].sel    = (sensor_idx[LANE_W-1:0] == LANE_W'(k));
      lane_cmd[k].din    = byte_value[LANES-1-k];
      lane_cmd[k].row    = row;
    end

    sett_lane #(
      .LANE        (k),
      .NUM_SENSORS (NUM_SENSORS),
      .TIME_BITS   (TIME_BITS)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .cmd      (lane_cmd[k]),
      .now      (now_t),
      .trig     (trig[k]),
      .rd_held  (rd_held[k]),
      .rd_stamp (rd_stamp[k])
    );
  end

  sett_merge #(
    .TIME_BITS (TIME_BITS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .mask      (trig),
    .row       (row),
    .now       (now_t),
    .query     (do_query),
    .qok       (sensor_ok),
    .qsensor   (sensor_number),
    .qlane     (sensor_idx[LANE_W-1:0]),
    .rd_held   (rd_held),
    .rd_stamp  (rd_stamp),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .sensor_id (sensor_id),
    .held      (held),
    .stamp     (stamp),
    .last      (last)
  );

endmodule

FILE: rtl/core/sett_lane.sv
`timescale 1ns / 1ps
// One sensor lane: held flags, stamp memory and edge detect for every eighth sensor.
module sett_lane #(
  parameter int LANE        = 0,
  parameter int NUM_SENSORS = 80,
  parameter int TIME_BITS   = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sett_pkg::lane_cmd_t    cmd,
  input  logic [TIME_BITS-1:0]   now,
  output logic                   trig,
  output logic                   rd_held,
  output logic [TIME_BITS-1:0]   rd_stamp
);
  import sett_pkg::*;

  localparam int ROWS  = (NUM_SENSORS + LANES - 1) / LANES;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [ROWS-1:0]      held_r;
  logic [ROWS-1:0]      stamped;
  logic [TIME_BITS-1:0] mem [ROWS];
  logic [TIME_BITS-1:0] rd_mem;
  logic                 rd_ok;

  logic [ROW_W-1:0] addr;
  logic [7:0]       sensor_idx;
  logic             in_range;
  logic             cur_held;

  assign addr       = cmd.row[ROW_W-1:0];
  assign sensor_idx = {1'b0, cmd.row, LANE_W'(LANE)};
  assign in_range   = sensor_idx < 8'(NUM_SENSORS);
  assign cur_held   = in_range && held_r[addr];

  always_comb begin
    trig = 1'b0;
    if (cmd.batch) begin
      trig = in_range && cmd.din && !cur_held;
    end else if (cmd.single) begin
      trig = cmd.sel && !cur_held;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_r  <= '0;
      stamped <= '0;
    end else begin
      if (cmd.batch && in_range) begin
        held_r[addr] <= cmd.din;
      end else if (cmd.single) begin
        held_r <= '0;
        if (cmd.sel) begin
          held_r[addr] <= 1'b1;
        end
      end
      if (trig) begin
        stamped[addr] <= 1'b1;
      end
    end
  end

  // stamp memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (trig) begin
      mem[addr] <= now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query) begin
      rd_mem <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query) begin
      rd_ok   <= in_range && stamped[addr];
      rd_held <= cur_held;
    end
  end

  // never-stamped entries read as zero
  assign rd_stamp = rd_ok ? rd_mem : '0;

endmodule

FILE: rtl/core/sett_merge.sv
`timescale 1ns / 1ps
// Merge stage: holds one item's lane results and sends them out one beat at a time.
module sett_merge #(
  parameter int TIME_BITS = 32
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           load,
  input  logic [sett_pkg::LANES-1:0]                     mask,
  input  logic [sett_pkg::ROW_IDX_W-1:0]                 row,
  input  logic [TIME_BITS-1:0]                           now,
  input  logic                                           query,
  input  logic                                           qok,
  input  logic [sett_pkg::ID_W-1:0]                      qsensor,
  input  logic [sett_pkg::LANE_W-1:0]                    qlane,
  input  logic [sett_pkg::LANES-1:0]                     rd_held,
  input  logic [sett_pkg::LANES-1:0][TIME_BITS-1:0]      rd_stamp,
  output logic                                           busy,
  output logic                                           out_valid,
  input  logic                                           out_stall,
  output logic [1:0]                                     kind,
  output logic [sett_pkg::ID_W-1:0]                      sensor_id,
  output logic                                           held,
  output logic [sett_pkg::STAMP_W-1:0]                   stamp,
  output logic                                           last
);
  import sett_pkg::*;

  logic                 pend_valid;
  logic [LANES-1:0]     pend_mask;
  logic [ROW_IDX_W-1:0] pend_row;
  logic [TIME_BITS-1:0] pend_now;
  logic                 pend_query;
  logic                 pend_qok;
  logic [ID_W-1:0]      pend_sensor;
  logic [LANE_W-1:0]    pend_lane;

  logic [LANE_W-1:0] pick;
  logic [LANES-1:0]  remaining;
  logic              out_load;
  logic              pend_done;
  logic [7:0]        trig_id;
  logic [63:0]       now_wide;
  logic [63:0]       rd_wide;

  // lowest set lane goes first, i.e. rising sensor number
  always_comb begin
    pick = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (pend_mask[i]) begin
        pick = LANE_W'(i);
      end
    end
  end

  assign remaining = pend_mask & ~(LANES'(1) << pick);
  assign out_load  = pend_valid && (!out_valid || !out_stall);
  assign pend_done = out_load && (pend_query || remaining == '0);
  assign busy      = pend_valid && !pend_done;

  assign trig_id  = {1'b0, pend_row, pick} + 8'd1;
  assign now_wide = 64'(pend_now);
  assign rd_wide  = 64'(rd_stamp[pend_lane]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (load) begin
      pend_valid <= query || (mask != '0);
    end else if (pend_done) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pend_mask   <= mask;
      pend_row    <= row;
      pend_now    <= now;
      pend_query  <= query;
      pend_qok    <= qok;
      pend_sensor <= qsensor;
      pend_lane   <= qlane;
    end else if (out_load) begin
      pend_mask <= remaining;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (pend_query) begin
        kind      <= pend_qok ? KIND_STATUS : KIND_INVALID;
        sensor_id <= pend_sensor;
        held      <= pend_qok && rd_held[pend_lane];
        stamp     <= pend_qok ? rd_wide[STAMP_W-1:0] : '0;
        last      <= 1'b1;
      end else begin
        kind      <= KIND_TRIGGER;
        sensor_id <= trig_id[ID_W-1:0];
        held      <= 1'b1;
        stamp     <= now_wide[STAMP_W-1:0];
        last      <= (remaining == '0);
      end
    end
  end

endmodule
